@@ rtl/fifo_page_replacement_macros.svh @@
// assertion macros for the fifo page replacement checker
`ifndef FIFO_PAGE_REPLACEMENT_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication, disabled during reset
`define FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

@@ rtl/fpr_pkg.sv @@
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W    = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int PAGE_W    = 16;
    localparam int FAULT_W   = 16;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              last_reference;
    } t_in_word;

    typedef struct packed {
        logic              page_fault;
        logic [3:0]        slot_loaded;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [FAULT_W-1:0] fault_count;
        logic              string_done;
    } t_out_word;

endpackage

@@ rtl/fpr_if.sv @@
`timescale 1ns / 1ps

// input word channel
interface fpr_in_if import fpr_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result word channel
interface fpr_out_if import fpr_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fpr_ram.sv @@
`timescale 1ns / 1ps

// simple dual-port ram, one write and one registered read per cycle
module fpr_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fifo_page_replacement.sv @@
`timescale 1ns / 1ps

// fifo page replacement: each input word is one page reference, and each yields one result
// word telling hit or fault, the frame loaded, the page evicted and the running fault count
// (saturating). frames_in_use picks how many frames take part (0 acts as 1, above 16 as 16);
// the user must write it only while the block is idle; the block does not enforce this. a
// word is accepted, each frame in use is read through the single read port of the frame
// memory and compared once its registered data arrives, and the result is committed once
// the output register is free. the scan stops early on a hit. a finished result waits in the
// output register, so a new word is accepted while it is still pending. after a word marked
// last the valid bits, pointer and count clear at once; stale frame data is masked by them.
module fifo_page_replacement import fpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    fpr_in_if.sink           i_in,
    fpr_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0] r_frames_in_use;

    // per-string state
    logic [FRAMES-1:0]  r_valid;
    logic [SLOT_W-1:0]  r_next_slot;
    logic [FAULT_W-1:0] r_faults;

    // current word
    logic [PAGE_W-1:0]  r_page;
    logic               r_last;
    logic [CNT_W-1:0]   r_n;       // active frame count, 1..FRAMES
    logic [SLOT_W-1:0]  r_slot;    // load slot after wrap
    logic [PAGE_W-1:0]  r_ev_page;
    logic               r_hit;

    // scan pipeline: read issue index, and compare index registered from it
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_cmp_vld;
    logic [SLOT_W-1:0]  r_cmp_idx;

    // result register
    logic      r_out_valid;
    t_out_word r_out;

    logic [PAGE_W-1:0]  w_rdata;
    logic               w_rd_go;
    logic               w_hit_now;
    logic               w_scan_end;
    logic               w_out_free;
    logic               w_commit;
    logic [CNT_W-1:0]   w_n_active;
    logic [SLOT_W-1:0]  w_slot_wrap;
    logic [CNT_W-1:0]   w_slot_inc;
    logic [SLOT_W-1:0]  n_next_slot;
    logic [FAULT_W-1:0] n_faults;

    // clamp the configured frame count into 1..FRAMES
    always_comb begin
        if (r_frames_in_use == '0) begin
            w_n_active = CNT_W'(1);
        end else if (CNT_W'(r_frames_in_use) > CNT_W'(FRAMES)) begin
            w_n_active = CNT_W'(FRAMES);
        end else begin
            w_n_active = CNT_W'(r_frames_in_use);
        end
    end

    // pointer left beyond a shrunk count wraps to frame 0 before use
    assign w_slot_wrap = ({1'b0, r_next_slot} >= w_n_active) ? '0 : r_next_slot;

    // one read per cycle until every active frame is issued or a hit shows up
    assign w_hit_now  = r_cmp_vld && r_valid[r_cmp_idx] && (w_rdata == r_page);
    assign w_scan_end = r_cmp_vld && ({1'b0, r_cmp_idx} == (r_n - CNT_W'(1)));
    assign w_rd_go    = (r_state == S_SCAN) && (r_rd_idx < r_n) && !w_hit_now;

    // commit only once the result register can take the word
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == S_FINISH) && w_out_free;

    assign w_slot_inc  = CNT_W'(r_slot) + CNT_W'(1);
    assign n_next_slot = (w_slot_inc >= r_n) ? '0 : SLOT_W'(w_slot_inc);
    assign n_faults    = (r_faults == FAULT_MAX) ? r_faults : r_faults + FAULT_W'(1);

    // frame memory: written only at commit, read only while scanning, so the two never
    // meet on one entry and the state machine itself is the interlock
    fpr_ram #(
        .DEPTH (FRAMES),
        .WIDTH (PAGE_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit && !r_hit),
        .i_waddr (r_slot),
        .i_wdata (r_page),
        .i_re    (w_rd_go),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frames_in_use <= CFG_RESET;
            r_valid         <= '0;
            r_next_slot     <= '0;
            r_faults        <= '0;
            r_cmp_vld       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end

            // result word enters on commit, leaves when taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // compare stage empties by itself once no read is issued
            r_cmp_vld <= w_rd_go;
            r_cmp_idx <= r_rd_idx[SLOT_W-1:0];
            if (w_rd_go) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_page   <= PAGE_W'(i_in.data.page_number[PAGE_BITS-1:0]);
                        r_last   <= i_in.data.last_reference;
                        r_n      <= w_n_active;
                        r_slot   <= w_slot_wrap;
                        r_rd_idx <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // keep the load slot's old page for the eviction report
                    if (r_cmp_vld && (r_cmp_idx == r_slot)) begin
                        r_ev_page <= w_rdata;
                    end
                    if (w_hit_now || w_scan_end) begin
                        r_hit     <= w_hit_now;
                        r_state   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out.page_fault       <= !r_hit;
                        r_out.slot_loaded      <= r_hit ? 4'd0 : 4'(r_slot);
                        r_out.evicted_valid    <= !r_hit && r_valid[r_slot];
                        r_out.evicted_page     <= (!r_hit && r_valid[r_slot]) ? r_ev_page : '0;
                        r_out.fault_count      <= r_hit ? r_faults : n_faults;
                        r_out.string_done      <= r_last;
                        if (r_last) begin
                            r_valid     <= '0;
                            r_next_slot <= '0;
                            r_faults    <= '0;
                        end else if (!r_hit) begin
                            r_valid[r_slot] <= 1'b1;
                            r_next_slot     <= n_next_slot;
                            r_faults        <= n_faults;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ rtl/fpr_checker.sv @@
`timescale 1ns / 1ps
`include "fifo_page_replacement_macros.svh"

module fpr_checker import fpr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_page_fault,
    input logic [3:0]         i_slot_loaded,
    input logic               i_evicted_valid,
    input logic [PAGE_W-1:0]  i_evicted_page
);

    // words accepted but not yet delivered
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    assign n_pend = r_pend + 2'(i_in_valid && i_in_ready) - 2'(i_out_valid && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `FPR_ASSERT_IMPLY(a_no_invented, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0)
    `FPR_ASSERT_IMPLY(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend != 2'd3)
    `FPR_ASSERT_IMPLY(a_hit_clean, i_clk, i_rst_n, i_out_valid && !i_page_fault, (i_slot_loaded == 4'd0) && !i_evicted_valid && (i_evicted_page == '0))
    `FPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_page_fault    (o_out.data.page_fault),
    .i_slot_loaded   (o_out.data.slot_loaded),
    .i_evicted_valid (o_out.data.evicted_valid),
    .i_evicted_page  (o_out.data.evicted_page)
);
